// ===== rtl/core/postfix_stack_evaluator_assert.svh =====
// Assertion macros used by the evaluator back end.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef POSTFIX_STACK_EVALUATOR_ASSERT_SVH
`define POSTFIX_STACK_EVALUATOR_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PSE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define PSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/pse_pkg.sv =====
// Shared types and constants for the postfix stack evaluator.
// No dependencies; imported by the top level, the front end, the divider and the back end.
`default_nettype none

package pse_pkg;

    localparam int WORD_W          = 32;
    localparam int NUM_W           = 31;
    localparam int ACT_W           = 3;
    localparam int STACK_DEPTH_DEF = 64;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [ACT_W-1:0] ACT_PUSH = 3'd0;
    localparam logic [ACT_W-1:0] ACT_ADD  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_SUB  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_MUL  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_DIV  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_END  = 3'd5;

    localparam logic [WORD_W-1:0] EMPTY_POP_VALUE = {WORD_W{1'b1}};

    typedef enum logic [2:0] {
        OP_PUSH,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_END
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [NUM_W-1:0] number;
    } t_token;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_B,
        S_RD_A,
        S_EXEC,
        S_DIV,
        S_RD_END
    } t_back_state;

endpackage

`default_nettype wire

// ===== rtl/core/postfix_stack_evaluator.sv =====
// Top level of the postfix stack evaluator: front queue plus execution back end.
// Depends on pse_pkg, pse_front and pse_back.
//
// Tokens enter as beats on start/i_action/i_number and are taken whenever busy is low;
// a two-entry queue absorbs them while the back end works. A push is written from idle, an
// end token reads the stack top first, add/subtract/multiply make two registered reads from
// the stack RAM, then execute, and divide also waits on the one-bit-per-cycle divider.
// Each end token yields one result beat: o_valid is high for a single cycle with
// o_final_value, o_was_empty and o_divided_by_zero, and the receiver cannot stall it.
// Action codes 6 and 7 are accepted and ignored. No clearing pass is needed after reset.
`default_nettype none

module postfix_stack_evaluator
    import pse_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [ACT_W-1:0]  i_action,
    input  wire logic [NUM_W-1:0]  i_number,
    output logic                   o_valid,
    output logic signed [WORD_W-1:0] o_final_value,
    output logic                   o_was_empty,
    output logic                   o_divided_by_zero
);

    t_token            tok;
    logic              tok_valid;
    logic              tok_pop;
    logic [WORD_W-1:0] final_value;

    pse_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_action    (i_action),
        .i_number    (i_number),
        .o_tok       (tok),
        .o_tok_valid (tok_valid),
        .i_tok_pop   (tok_pop)
    );

    pse_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_tok             (tok),
        .i_tok_valid       (tok_valid),
        .o_tok_pop         (tok_pop),
        .o_valid           (o_valid),
        .o_final_value     (final_value),
        .o_was_empty       (o_was_empty),
        .o_divided_by_zero (o_divided_by_zero)
    );

    assign o_final_value = signed'(final_value);

endmodule

`default_nettype wire

// ===== rtl/core/pse_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/core/pse_front.sv =====
// Front end: accepts token beats, classifies the action code and queues tokens.
// Depends on pse_pkg.
`default_nettype none

module pse_front
    import pse_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [ACT_W-1:0] i_action,
    input  wire logic [NUM_W-1:0] i_number,
    output t_token                o_tok,
    output logic                  o_tok_valid,
    input  wire logic             i_tok_pop
);

    t_token     r_mem [QUEUE_DEPTH];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_cnt;

    t_token     cls_tok;
    logic       cls_ok;
    logic       enq;

    always_comb begin
        cls_tok.number = i_number;
        cls_tok.op     = OP_PUSH;
        cls_ok         = 1'b1;
        case (i_action)
            ACT_PUSH: cls_tok.op = OP_PUSH;
            ACT_ADD:  cls_tok.op = OP_ADD;
            ACT_SUB:  cls_tok.op = OP_SUB;
            ACT_MUL:  cls_tok.op = OP_MUL;
            ACT_DIV:  cls_tok.op = OP_DIV;
            ACT_END:  cls_tok.op = OP_END;
            default:  cls_ok     = 1'b0;
        endcase
    end

    assign busy        = (r_cnt == 2'(QUEUE_DEPTH));
    // Unused action codes are taken from the port and then dropped here.
    assign enq         = start && !busy && cls_ok;
    assign o_tok       = r_mem[r_rptr];
    assign o_tok_valid = (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_mem[r_wptr] <= cls_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (enq) begin
                r_wptr <= !r_wptr;
            end
            if (i_tok_pop) begin
                r_rptr <= !r_rptr;
            end
            r_cnt <= r_cnt + 2'(enq) - 2'(i_tok_pop);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/pse_div.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on pse_pkg.
`default_nettype none

module pse_div
    import pse_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [WORD_W-1:0] i_dividend,
    input  wire logic [WORD_W-1:0] i_divisor,
    output logic                   o_done,
    output logic      [WORD_W-1:0] o_quotient
);

    localparam int STEP_W = $clog2(WORD_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic              r_neg;
    logic [WORD_W-1:0] r_quo;
    logic [WORD_W-1:0] r_rem;
    logic [WORD_W-1:0] r_den;

    logic [WORD_W:0]   rem_sh;
    logic [WORD_W:0]   diff;

    // The dividend shifts out of the quotient register as quotient bits shift in.
    assign rem_sh = {r_rem, r_quo[WORD_W-1]};
    assign diff   = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[WORD_W-1] ^ i_divisor[WORD_W-1];
            r_quo <= i_dividend[WORD_W-1] ? (WORD_W'(0) - i_dividend) : i_dividend;
            r_den <= i_divisor[WORD_W-1] ? (WORD_W'(0) - i_divisor) : i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            if (!diff[WORD_W]) begin
                r_rem <= diff[WORD_W-1:0];
                r_quo <= {r_quo[WORD_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[WORD_W-1:0];
                r_quo <= {r_quo[WORD_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(WORD_W);
            end else if (r_busy) begin
                r_step <= r_step - STEP_W'(1);
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? (WORD_W'(0) - r_quo) : r_quo;

endmodule

`default_nettype wire

// ===== rtl/core/pse_back.sv =====
// Back end: runs queued tokens against the value stack and the divider.
// Depends on pse_pkg, pse_ram, pse_div and the assertion macro header.
`default_nettype none
`include "postfix_stack_evaluator_assert.svh"

module pse_back
    import pse_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  t_token            i_tok,
    input  wire logic         i_tok_valid,
    output logic              o_tok_pop,
    output logic              o_valid,
    output logic [WORD_W-1:0] o_final_value,
    output logic              o_was_empty,
    output logic              o_divided_by_zero
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    t_back_state       r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    t_op               r_op, n_op;
    logic [WORD_W-1:0] r_a, n_a;
    logic [WORD_W-1:0] r_b, n_b;
    logic              r_zdiv, n_zdiv;
    logic              r_out_valid, n_out_valid;
    logic [WORD_W-1:0] r_out_value, n_out_value;
    logic              r_out_empty, n_out_empty;
    logic              r_out_zdiv, n_out_zdiv;

    logic              ram_we;
    logic [WORD_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_rdata;
    logic              div_start;
    logic              div_done;
    logic [WORD_W-1:0] div_quot;

    logic [CW-1:0]     cnt_m1;
    logic [CW-1:0]     cnt_m2;
    logic              has_room;
    logic [WORD_W-1:0] exec_res;
    logic              exec_push;

    assign cnt_m1   = r_count - CW'(1);
    assign cnt_m2   = r_count - CW'(2);
    assign has_room = (r_count < CW'(STACK_DEPTH));
    // The top entry is read in IDLE, the one beneath it in RD_B.
    assign ram_raddr = (r_state == S_RD_B) ? cnt_m2[AW-1:0] : cnt_m1[AW-1:0];

    pse_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    pse_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_a),
        .i_divisor  (r_b),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    always_comb begin
        exec_res  = '0;
        exec_push = 1'b1;
        unique case (r_op)
            OP_ADD: exec_res = r_a + r_b;
            OP_SUB: exec_res = r_a - r_b;
            OP_MUL: exec_res = r_a * r_b;
            OP_DIV: begin
                // A zero divisor pushes zero; anything else goes to the divider.
                exec_res  = '0;
                exec_push = (r_b == '0);
            end
            OP_PUSH, OP_END: exec_push = 1'b0;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_op        = r_op;
        n_a         = r_a;
        n_b         = r_b;
        n_zdiv      = r_zdiv;
        n_out_valid = 1'b0;
        n_out_value = r_out_value;
        n_out_empty = r_out_empty;
        n_out_zdiv  = r_out_zdiv;
        ram_we      = 1'b0;
        ram_wdata   = '0;
        o_tok_pop   = 1'b0;
        div_start   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_tok_valid) begin
                    o_tok_pop = 1'b1;
                    n_op      = i_tok.op;
                    unique case (i_tok.op)
                        OP_PUSH: begin
                            if (has_room) begin
                                ram_we    = 1'b1;
                                ram_wdata = {1'b0, i_tok.number};
                                n_count   = r_count + CW'(1);
                            end
                        end
                        OP_END: n_state = S_RD_END;
                        OP_ADD, OP_SUB, OP_MUL, OP_DIV: n_state = S_RD_B;
                    endcase
                end
            end
            S_RD_B: begin
                n_b     = (r_count != '0) ? ram_rdata : EMPTY_POP_VALUE;
                n_state = S_RD_A;
            end
            S_RD_A: begin
                if (r_count >= CW'(2)) begin
                    n_a     = ram_rdata;
                    n_count = cnt_m2;
                end else begin
                    n_a     = EMPTY_POP_VALUE;
                    n_count = '0;
                end
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (r_op == OP_DIV && r_b == '0) begin
                    n_zdiv = 1'b1;
                end
                if (exec_push) begin
                    if (has_room) begin
                        ram_we    = 1'b1;
                        ram_wdata = exec_res;
                        n_count   = r_count + CW'(1);
                    end
                    n_state = S_IDLE;
                end else if (r_op == OP_DIV) begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    if (has_room) begin
                        ram_we    = 1'b1;
                        ram_wdata = div_quot;
                        n_count   = r_count + CW'(1);
                    end
                    n_state = S_IDLE;
                end
            end
            S_RD_END: begin
                n_out_valid = 1'b1;
                n_out_value = (r_count != '0) ? ram_rdata : EMPTY_POP_VALUE;
                n_out_empty = (r_count == '0);
                n_out_zdiv  = r_zdiv;
                n_count     = '0;
                n_zdiv      = 1'b0;
                n_state     = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_op        <= OP_PUSH;
            r_zdiv      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_op        <= n_op;
            r_zdiv      <= n_zdiv;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a         <= n_a;
        r_b         <= n_b;
        r_out_value <= n_out_value;
        r_out_empty <= n_out_empty;
        r_out_zdiv  <= n_out_zdiv;
    end

    assign o_valid           = r_out_valid;
    assign o_final_value     = r_out_value;
    assign o_was_empty       = r_out_empty;
    assign o_divided_by_zero = r_out_zdiv;

    `PSE_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CW'(STACK_DEPTH), "stack count overflow")
    `PSE_ASSERT_NEXT(a_end_emits, r_state == S_RD_END, r_out_valid && r_state == S_IDLE, "end beat without result")
    `PSE_ASSERT_NOW(a_div_nonzero, div_start, r_b != '0 && r_op == OP_DIV, "divider started on zero divisor")
    `PSE_ASSERT_NOW(a_div_owner, div_done, r_state == S_DIV, "divider finished outside divide state")

endmodule

`default_nettype wire
